FILE: rtl/pwsfd_pkg.sv
// pwsfd_pkg: shared types and constants for the pulse width sensor frame decoder
// phase codes, word status codes, register indexes and register reset values
// no dependencies
package pwsfd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W   = 3;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 3;
  localparam int HUM_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int CSUM_W    = 8;

  localparam logic [COUNT_W-1:0] HUM_BITS  = 5'd16;
  localparam logic [COUNT_W-1:0] TEMP_BITS = 5'd16;
  localparam logic [COUNT_W-1:0] CSUM_BITS = 5'd8;

  localparam logic [PHASE_W-1:0] PH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUM   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TEMP  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CSUM  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_ERR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_RECV = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGN  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd4;

  localparam logic [CFG_W-1:0] START_MIN_RST = 16'd129;
  localparam logic [CFG_W-1:0] START_MAX_RST = 16'd180;
  localparam logic [CFG_W-1:0] ONE_MIN_RST   = 16'd101;
  localparam logic [CFG_W-1:0] ONE_MAX_RST   = 16'd160;
  localparam logic [CFG_W-1:0] ZERO_MIN_RST  = 16'd68;

  typedef struct packed {
    logic [CFG_W-1:0] start_min_us;
    logic [CFG_W-1:0] start_max_us;
    logic [CFG_W-1:0] one_min_us;
    logic [CFG_W-1:0] one_max_us;
    logic [CFG_W-1:0] zero_min_us;
  } cfg_t;

endpackage

FILE: rtl/pulse_width_sensor_frame_decoder_top.sv
// pulse_width_sensor_frame_decoder_top: decodes interval words into a sensor frame
// start window check, bit classification, shift registers and checksum compare
// depends on pwsfd_pkg
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------------
//  in      | in_valid / in_ready         | op, interval_us
//  out     | out_valid / out_ready       | status, humidity_raw, temperature_raw,
//          |                             | checksum_raw
//  cfg     | cfg_write                   | cfg_index, cfg_data
//
// one word per cycle while in_ready is high; the result is registered on acceptance
// the whole decode is one compare-and-shift stage between the word and the result register
// in_ready is high while the result register is empty or being taken in the same cycle
// reset clears phase, bit count, shift registers and out_valid; registers get reset values
// an output stall holds the result and stalls the input only while it lasts
module pulse_width_sensor_frame_decoder_top
  import pwsfd_pkg::*;
#(
  parameter int INTERVAL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [INTERVAL_BITS-1:0] interval_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [HUM_W-1:0]         humidity_raw,
  output logic [TEMP_W-1:0]        temperature_raw,
  output logic [CSUM_W-1:0]        checksum_raw,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int CMP_W = (INTERVAL_BITS > CFG_W) ? INTERVAL_BITS : CFG_W;

  cfg_t                cfg;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [COUNT_W-1:0]  bit_count, bit_count_next, count_inc;
  logic [HUM_W-1:0]    humidity_shift, humidity_next;
  logic [TEMP_W-1:0]   temperature_shift, temperature_next;
  logic [CSUM_W-1:0]   checksum_shift, checksum_next;
  logic [STATUS_W-1:0] status_next;
  logic                accept;

  logic [CMP_W-1:0]    t, start_min, start_max, one_min, one_max, zero_min;
  logic                start_hit, is_one, is_zero, bit_val;
  logic [CSUM_W-1:0]   byte_sum;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_min_us <= START_MIN_RST;
      cfg.start_max_us <= START_MAX_RST;
      cfg.one_min_us   <= ONE_MIN_RST;
      cfg.one_max_us   <= ONE_MAX_RST;
      cfg.zero_min_us  <= ZERO_MIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_MIN: cfg.start_min_us <= cfg_data;
        REG_START_MAX: cfg.start_max_us <= cfg_data;
        REG_ONE_MIN:   cfg.one_min_us   <= cfg_data;
        REG_ONE_MAX:   cfg.one_max_us   <= cfg_data;
        REG_ZERO_MIN:  cfg.zero_min_us  <= cfg_data;
        default: ;
      endcase
    end
  end

  // interval classification
  assign t         = CMP_W'(interval_us);
  assign start_min = CMP_W'(cfg.start_min_us);
  assign start_max = CMP_W'(cfg.start_max_us);
  assign one_min   = CMP_W'(cfg.one_min_us);
  assign one_max   = CMP_W'(cfg.one_max_us);
  assign zero_min  = CMP_W'(cfg.zero_min_us);

  assign start_hit = (t >= start_min) && (t <= start_max);
  assign is_one    = (t >= one_min) && (t < one_max);
  assign is_zero   = (t >= zero_min) && (t < one_min);
  assign bit_val   = is_one;
  assign count_inc = bit_count + COUNT_W'(1);

  assign byte_sum = humidity_shift[HUM_W-1 -: CSUM_W] + humidity_shift[CSUM_W-1:0]
                  + temperature_shift[TEMP_W-1 -: CSUM_W] + temperature_shift[CSUM_W-1:0];

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    humidity_next    = humidity_shift;
    temperature_next = temperature_shift;
    checksum_next    = checksum_shift;
    status_next      = ST_RECV;
    if (op) begin
      phase_next     = PH_START;
      bit_count_next = '0;
    end else begin
      case (phase)
        PH_START: begin
          if (start_hit) begin
            phase_next     = PH_HUM;
            bit_count_next = '0;
          end else begin
            phase_next  = PH_ERR;
            status_next = ST_TIME;
          end
        end
        PH_HUM, PH_TEMP, PH_CSUM: begin
          if (!is_one && !is_zero) begin
            phase_next  = PH_ERR;
            status_next = ST_TIME;
          end else begin
            bit_count_next = count_inc;
            if (phase == PH_HUM) begin
              humidity_next = {humidity_shift[HUM_W-2:0], bit_val};
              if (count_inc >= HUM_BITS) begin
                bit_count_next = '0;
                phase_next     = PH_TEMP;
              end
            end else if (phase == PH_TEMP) begin
              temperature_next = {temperature_shift[TEMP_W-2:0], bit_val};
              if (count_inc >= TEMP_BITS) begin
                bit_count_next = '0;
                phase_next     = PH_CSUM;
              end
            end else begin
              checksum_next = {checksum_shift[CSUM_W-2:0], bit_val};
              if (count_inc >= CSUM_BITS) begin
                status_next    = (byte_sum == checksum_next) ? ST_OK : ST_BAD;
                bit_count_next = '0;
                phase_next     = PH_DONE;
              end
            end
          end
        end
        default: begin
          status_next = ST_IGN;
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_START;
      bit_count         <= '0;
      humidity_shift    <= '0;
      temperature_shift <= '0;
      checksum_shift    <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      bit_count         <= bit_count_next;
      humidity_shift    <= humidity_next;
      temperature_shift <= temperature_next;
      checksum_shift    <= checksum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      humidity_raw    <= humidity_next;
      temperature_raw <= temperature_next;
      checksum_raw    <= checksum_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count < HUM_BITS)
    else $error("bit count out of range");

  a_csum_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CSUM |-> bit_count < CSUM_BITS)
    else $error("checksum bit count out of range");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> bit_count == '0)
    else $error("bit count not cleared while waiting for start");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK || status == ST_BAD) |-> phase == PH_DONE)
    else $error("frame result without done phase");

  a_timing_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TIME |-> phase == PH_ERR)
    else $error("timing error result without error phase");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase))
    else $error("state moved while result stalled");

endmodule
